FILE: hw/rtl/cgr_pkg.sv
// Shared types, constants and helper functions of the glyph cell rasterizer.
package cgr_pkg;

    localparam int GLYPH_COLS    = 8;
    localparam int MASK_W        = GLYPH_COLS + 1;
    localparam int UNDERLINE_ROW = 15;
    localparam int FRAME_MAX     = 4096;
    localparam int DIM_W         = 13;
    localparam int COORD_W       = 16;
    localparam int ROWY_W        = 12;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_DRAW = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                       command;
        logic                       new_run;
        logic signed [COORD_W-1:0]  cell_x;
        logic signed [COORD_W-1:0]  cell_y;
        logic [7:0]                 glyph_code;
        logic [3:0]                 font_row;
        logic [7:0]                 font_bits;
        logic [31:0]                ink_color;
        logic                       bold;
        logic                       underline;
    } t_req;

    typedef struct packed {
        logic [ROWY_W-1:0]          row_y;
        logic signed [COORD_W-1:0]  base_x;
        logic [MASK_W-1:0]          pixel_mask;
        logic [31:0]                pixel_color;
        logic                       last_row;
    } t_resp;

    // One classified request as it waits between the front and back ends.
    typedef struct packed {
        logic                       is_draw;
        logic                       load_ok;
        logic                       glyph_ok;
        logic [7:0]                 code;
        logic [3:0]                 frow;
        logic [7:0]                 fbits;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [MASK_W-1:0]          clip;
        logic [31:0]                ink;
        logic                       bold;
        logic                       uline;
    } t_job;

    typedef struct packed {
        logic busy;
        logic pend_valid;
        logic pend_final;
    } t_back_stat;

    // Frame sizes above the maximum behave as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(FRAME_MAX)) ? DIM_W'(FRAME_MAX) : v;
    endfunction

    // Font bit 7 is the leftmost pixel, which becomes mask bit 0.
    function automatic logic [MASK_W-1:0] rev_row(input logic [7:0] bits);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int col = 0; col < GLYPH_COLS; col++) begin
            m[col] = bits[GLYPH_COLS-1-col];
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/cgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/cgr_fifo.sv
// Small register FIFO used for the job queue and the result queue.
module cgr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/cgr_front.sv
// Front end: accepts requests, tracks the pen position and works out column clipping.
module cgr_front #(
    parameter int GLYPH_ROWS  = 16,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  cgr_pkg::t_req               i_req,
    output logic                        o_stall,
    input  logic                        i_full,
    input  logic [cgr_pkg::DIM_W-1:0]   i_frame_w,
    output logic                        o_push,
    output cgr_pkg::t_job               o_job
);

    import cgr_pkg::*;

    logic [COORD_W-1:0] r_pen_x;
    logic [COORD_W-1:0] n_pen_x;
    logic               w_accept;
    logic [DIM_W-1:0]   w_width;
    logic [MASK_W-1:0]  w_clip;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;
    assign w_width  = clamp_dim(i_frame_w);

    // A continued run starts one cell to the right of the previous cell.
    assign n_pen_x = i_req.new_run ? i_req.cell_x : r_pen_x + COORD_W'(GLYPH_COLS);

    always_comb begin
        logic [COORD_W+1:0] px;
        for (int i = 0; i < MASK_W; i++) begin
            px        = {{2{n_pen_x[COORD_W-1]}}, n_pen_x} + (COORD_W+2)'(i);
            w_clip[i] = !px[COORD_W+1] && (px < {{(COORD_W+2-DIM_W){1'b0}}, w_width});
        end
    end

    always_comb begin
        o_job          = '0;
        o_job.is_draw  = (i_req.command == CMD_DRAW);
        o_job.load_ok  = (int'(i_req.font_row) < GLYPH_ROWS)
                      && (int'(i_req.glyph_code) < GLYPH_COUNT);
        o_job.glyph_ok = (int'(i_req.glyph_code) < GLYPH_COUNT);
        o_job.code     = i_req.glyph_code;
        o_job.frow     = i_req.font_row;
        o_job.fbits    = i_req.font_bits;
        o_job.x        = n_pen_x;
        o_job.y        = i_req.cell_y;
        o_job.clip     = w_clip;
        o_job.ink      = i_req.ink_color;
        o_job.bold     = i_req.bold;
        o_job.uline    = i_req.underline;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x <= '0;
        end else if (w_accept && (i_req.command == CMD_DRAW)) begin
            r_pen_x <= n_pen_x;
        end
    end

endmodule

FILE: hw/rtl/cgr_back.sv
// Back end: font store access, per-row mask build, last-row tagging and result queue.
module cgr_back #(
    parameter int GLYPH_ROWS  = 16,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_job_valid,
    input  cgr_pkg::t_job                                 i_job,
    output logic                                          o_job_pop,
    input  logic [cgr_pkg::DIM_W-1:0]                     i_frame_h,
    output logic                                          o_ram_we,
    output logic [$clog2(GLYPH_COUNT*GLYPH_ROWS)-1:0]     o_ram_waddr,
    output logic [7:0]                                    o_ram_wdata,
    output logic                                          o_ram_re,
    output logic [$clog2(GLYPH_COUNT*GLYPH_ROWS)-1:0]     o_ram_raddr,
    input  logic [7:0]                                    i_ram_rdata,
    output logic                                          o_valid,
    input  logic                                          i_stall,
    output cgr_pkg::t_resp                                o_resp,
    output cgr_pkg::t_back_stat                           o_stat
);

    import cgr_pkg::*;

    localparam int ADDR_W = $clog2(GLYPH_COUNT * GLYPH_ROWS);
    localparam int ROW_W  = $clog2(GLYPH_ROWS);

    function automatic logic [ADDR_W-1:0] glyph_addr(input int code, input int row);
        return ADDR_W'(code * GLYPH_ROWS + row);
    endfunction

    // Issue stage
    logic             r_busy;
    t_job             r_job;
    logic [ROW_W-1:0] r_row;
    logic             w_adv;
    logic             w_pop;
    logic             s0_valid;
    t_job             s0_job;
    logic [ROW_W-1:0] s0_row;
    logic             s0_end;

    // Mask stage, aligned with the font store read data
    logic             r_s1_valid;
    t_job             r_s1_job;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_end;
    logic [COORD_W+1:0] w_py;
    logic             w_vis;
    logic [MASK_W-1:0] w_mask;
    logic             w_hit;
    t_resp            w_new;

    // Pending row held until the next row or the end of the cell decides last_row
    logic             r_p_valid;
    logic             r_p_final;
    t_resp            r_p;
    logic             n_p_valid;
    logic             n_p_final;
    t_resp            n_p;
    logic             w_push;
    t_resp            w_push_data;

    logic             w_ofull;
    logic             w_oempty;
    logic [DIM_W-1:0] w_height;

    assign w_height = clamp_dim(i_frame_h);
    assign w_adv    = !w_ofull;
    assign w_pop    = w_adv && !r_busy && i_job_valid;
    assign o_job_pop = w_pop;

    assign s0_job   = r_busy ? r_job : i_job;
    assign s0_row   = r_busy ? r_row : '0;
    assign s0_valid = w_adv && (r_busy || (w_pop && i_job.is_draw));
    assign s0_end   = (s0_row == ROW_W'(GLYPH_ROWS - 1));

    assign o_ram_we    = w_pop && !i_job.is_draw && i_job.load_ok;
    assign o_ram_waddr = glyph_addr(int'(i_job.code), int'(i_job.frow));
    assign o_ram_wdata = i_job.fbits;
    assign o_ram_re    = s0_valid;
    assign o_ram_raddr = glyph_addr(int'(s0_job.code), int'(s0_row));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (s0_valid) begin
            r_busy <= !s0_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_valid) begin
            r_job <= s0_job;
            r_row <= s0_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_job <= s0_job;
            r_s1_row <= s0_row;
            r_s1_end <= s0_end;
        end
    end

    always_comb begin
        logic [7:0] glyph;
        w_py  = {{2{r_s1_job.y[COORD_W-1]}}, r_s1_job.y} + (COORD_W+2)'(r_s1_row);
        w_vis = !w_py[COORD_W+1] && (w_py < {{(COORD_W+2-DIM_W){1'b0}}, w_height});
        glyph = r_s1_job.glyph_ok ? i_ram_rdata : 8'h00;
        w_mask = rev_row(glyph);
        if (r_s1_job.bold) begin
            w_mask = w_mask | (w_mask << 1);
        end
        if (r_s1_job.uline && (int'(r_s1_row) == UNDERLINE_ROW)) begin
            w_mask = w_mask | MASK_W'({GLYPH_COLS{1'b1}});
        end
        w_mask = w_mask & r_s1_job.clip;
        w_hit  = r_s1_valid && w_vis && (w_mask != '0);

        w_new             = '0;
        w_new.row_y       = w_py[ROWY_W-1:0];
        w_new.base_x      = r_s1_job.x;
        w_new.pixel_mask  = w_mask;
        w_new.pixel_color = r_s1_job.ink;
        w_new.last_row    = 1'b0;
    end

    always_comb begin
        logic end_here;
        end_here    = r_s1_valid && r_s1_end;
        w_push      = 1'b0;
        w_push_data = r_p;
        n_p_valid   = r_p_valid;
        n_p_final   = r_p_final;
        n_p         = r_p;
        if (r_p_valid && r_p_final) begin
            w_push               = 1'b1;
            w_push_data.last_row = 1'b1;
            n_p_valid            = w_hit;
            n_p_final            = w_hit && end_here;
            n_p                  = w_new;
        end else if (w_hit) begin
            w_push               = r_p_valid;
            w_push_data.last_row = 1'b0;
            n_p_valid            = 1'b1;
            n_p_final            = end_here;
            n_p                  = w_new;
        end else begin
            n_p_final = r_p_valid && end_here;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_final <= 1'b0;
        end else if (w_adv) begin
            r_p_valid <= n_p_valid;
            r_p_final <= n_p_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p <= n_p;
        end
    end

    cgr_fifo #(
        .WIDTH ($bits(t_resp)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push && w_adv),
        .i_data  (w_push_data),
        .i_pop   (o_valid && !i_stall),
        .o_data  (o_resp),
        .o_empty (w_oempty),
        .o_full  (w_ofull)
    );

    assign o_valid = !w_oempty;

    assign o_stat.busy       = r_busy;
    assign o_stat.pend_valid = r_p_valid;
    assign o_stat.pend_final = r_p_final;

endmodule

FILE: hw/rtl/clipped_glyph_cell_rasterizer_core.sv
// Top level of the clipped glyph cell rasterizer: configuration, queues and font store.
//
// Request channel (i_valid, o_stall, i_req): a load request writes one font row into
// the font store and produces nothing; a draw request renders one 8-pixel-wide cell.
// A request is taken at a rising edge with i_valid high and o_stall low. o_stall rises
// only when the four-entry job queue between the front and back ends is full.
// Result channel (o_valid, i_stall, o_resp): one masked row write per visible, non-empty
// cell row, top row first, with last_row set on the final write of the character.
// The back end walks every cell row at one font store read per cycle while the result
// queue has room, and takes no new request until the sweep is done. A row is
// held until the next non-empty row or the end of the sweep settles its last_row flag.
// When the receiver stalls, a two-entry result queue fills, the back end freezes in
// place, and the job queue then absorbs up to four further requests before o_stall rises.
// Reset is synchronous and active low: pen position cleared, frame size 1024 by 768,
// queues emptied. The font store is not cleared and must be loaded before use.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) should only occur while idle.
module clipped_glyph_cell_rasterizer_core #(
    parameter int GLYPH_ROWS  = 16,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  cgr_pkg::t_req               i_req,
    output logic                        o_valid,
    input  logic                        i_stall,
    output cgr_pkg::t_resp              o_resp,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [cgr_pkg::DIM_W-1:0]   i_cfg_data
);

    import cgr_pkg::*;

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int ADDR_W     = $clog2(FONT_DEPTH);

    logic [DIM_W-1:0] r_frame_w;
    logic [DIM_W-1:0] r_frame_h;

    logic             w_jq_push;
    t_job             w_jq_in;
    t_job             w_jq_out;
    logic             w_jq_pop;
    logic             w_jq_empty;
    logic             w_jq_full;

    logic             w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [7:0]       w_ram_wdata;
    logic             w_ram_re;
    logic [ADDR_W-1:0] w_ram_raddr;
    logic [7:0]       w_ram_rdata;
    t_back_stat       w_stat;

    // Frame size registers; values above the maximum are clamped where they are used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= DIM_W'(1024);
            r_frame_h <= DIM_W'(768);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH: begin
                    r_frame_w <= i_cfg_data;
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_h <= i_cfg_data;
                end
                default: begin
                    r_frame_w <= r_frame_w;
                end
            endcase
        end
    end

    // The front end resolves the cell position and column clip at request time.
    cgr_front #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_req     (i_req),
        .o_stall   (o_stall),
        .i_full    (w_jq_full),
        .i_frame_w (r_frame_w),
        .o_push    (w_jq_push),
        .o_job     (w_jq_in)
    );

    // Loads travel through the queue too, so they never overtake an earlier draw.
    cgr_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (4)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_jq_push),
        .i_data  (w_jq_in),
        .i_pop   (w_jq_pop),
        .o_data  (w_jq_out),
        .o_empty (w_jq_empty),
        .o_full  (w_jq_full)
    );

    cgr_back #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_jq_empty),
        .i_job       (w_jq_out),
        .o_job_pop   (w_jq_pop),
        .i_frame_h   (r_frame_h),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_resp      (o_resp),
        .o_stat      (w_stat)
    );

    // Font store: one byte per glyph row, addressed by code times rows plus row.
    cgr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Empty rows are dropped, so every delivered row writes at least one pixel.
    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_resp.pixel_mask != '0))
        else $error("row write with empty pixel mask");

    // A row can only be marked final while it is actually held.
    a_final_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.pend_final |-> w_stat.pend_valid)
        else $error("final flag set without a pending row");

    // A font load must never land in the middle of a cell's row sweep.
    a_load_outside_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (!w_stat.busy && !w_ram_re))
        else $error("font load during a draw sweep");

endmodule

FILE: tb/clipped_glyph_cell_rasterizer_core_tb.sv
// Self-checking testbench for the clipped glyph cell rasterizer core.
`timescale 1ns / 100ps

module clipped_glyph_cell_rasterizer_core_tb;

    import cgr_pkg::*;

    // Geometry of one character cell, as built with the default parameters.
    localparam int CELL_ROWS      = 16;
    localparam int GLYPH_SLOTS    = 256;
    // Cycles to wait once every expected row write has arrived. Draws that
    // produce nothing may still sit in the four-deep job queue, and each one
    // holds the back end for a full row sweep.
    localparam int SETTLE_CYCLES  = 120;
    // Cycles with neither a request nor a row write accepted before giving up.
    localparam int WATCHDOG_LIMIT = 3000;

    logic   i_clk      = 1'b0;
    logic   i_rst_n    = 1'b0;
    logic   i_valid    = 1'b0;
    logic   o_stall;
    t_req   i_req      = '0;
    logic   o_valid;
    logic   i_stall    = 1'b0;
    t_resp  o_resp;
    logic   i_cfg_we   = 1'b0;
    logic   [0:0] i_cfg_idx = CFG_FRAME_WIDTH;
    logic   [DIM_W-1:0] i_cfg_data = '0;

    clipped_glyph_cell_rasterizer_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_resp     (o_resp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Shadow copy of the block's state, advanced as each request is taken.
    logic [7:0]       font_img [GLYPH_SLOTS*CELL_ROWS];
    logic [15:0]      pen_col = '0;
    logic [DIM_W-1:0] frame_w = 13'd1024;
    logic [DIM_W-1:0] frame_h = 13'd768;

    // Row writes predicted but not yet seen on the result channel, oldest first.
    t_resp row_writes_due [$];

    // Requests waiting for the driver, and the bookkeeping used to pick
    // only glyphs whose sixteen rows have all been loaded.
    t_req        requests_pending [$];
    logic [15:0] rows_loaded [GLYPH_SLOTS];
    logic [7:0]  ready_glyphs [$];

    int  reqs_queued     = 0;
    int  reqs_taken      = 0;
    int  mismatch_count  = 0;
    int  quiet_cycles    = 0;
    int  src_gap_pct     = 0;
    int  sink_gap_pct    = 0;
    int  src_gap_left    = 0;
    int  sink_gap_left   = 0;
    bit  req_taken       = 1'b0;
    t_resp due_write;

    initial begin
        for (int g = 0; g < GLYPH_SLOTS; g++) begin
            rows_loaded[g] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        mismatch_count++;
    endtask

    // Works out the row writes of one accepted request. A load only updates
    // the font image; a draw sweeps all cell rows, builds the row mask from the
    // mirrored glyph byte, the bold strike and the underline bar, clips it and
    // queues every non-empty row, flagging the last one.
    task automatic predict_request(input t_req r);
        int          x;
        int          y;
        int          w;
        int          h;
        int          py;
        logic [8:0]  clip;
        logic [8:0]  m;
        logic [7:0]  bits;
        t_resp       held;
        bit          have_held;
        if (r.command == CMD_LOAD) begin
            font_img[{r.glyph_code, r.font_row}] = r.font_bits;
            return;
        end
        pen_col = r.new_run ? r.cell_x : pen_col + 16'(GLYPH_COLS);
        x = int'($signed(pen_col));
        y = int'($signed(r.cell_y));
        w = (frame_w > DIM_W'(FRAME_MAX)) ? FRAME_MAX : int'(frame_w);
        h = (frame_h > DIM_W'(FRAME_MAX)) ? FRAME_MAX : int'(frame_h);
        clip = '0;
        for (int i = 0; i <= GLYPH_COLS; i++) begin
            clip[i] = (x + i >= 0) && (x + i < w);
        end
        have_held = 1'b0;
        held = '0;
        for (int row = 0; row < CELL_ROWS; row++) begin
            py = y + row;
            if (py < 0 || py >= h) continue;
            bits = font_img[{r.glyph_code, 4'(row)}];
            m = '0;
            for (int c = 0; c < GLYPH_COLS; c++) begin
                m[c] = bits[GLYPH_COLS-1-c];
            end
            if (r.bold) m = m | (m << 1);
            if (r.underline && row == UNDERLINE_ROW) m = m | 9'h0FF;
            m = m & clip;
            if (m == '0) continue;
            if (have_held) row_writes_due.push_back(held);
            held.row_y       = ROWY_W'(py);
            held.base_x      = pen_col;
            held.pixel_mask  = m;
            held.pixel_color = r.ink_color;
            held.last_row    = 1'b0;
            have_held = 1'b1;
        end
        if (have_held) begin
            held.last_row = 1'b1;
            row_writes_due.push_back(held);
        end
    endtask

    // Result checking, request capture and the watchdog, all on the rising
    // edge. Results are checked before the new request is predicted, so a row
    // write always meets the expectations of earlier requests first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (row_writes_due.size() == 0) begin
                    report_mismatch("row write with none expected", 32'(o_resp.row_y), '0);
                end else begin
                    due_write = row_writes_due.pop_front();
                    if (o_resp.row_y != due_write.row_y)
                        report_mismatch("row_y", 32'(o_resp.row_y), 32'(due_write.row_y));
                    if (o_resp.base_x != due_write.base_x)
                        report_mismatch("base_x", 32'(o_resp.base_x), 32'(due_write.base_x));
                    if (o_resp.pixel_mask != due_write.pixel_mask)
                        report_mismatch("pixel_mask", 32'(o_resp.pixel_mask),
                                        32'(due_write.pixel_mask));
                    if (o_resp.pixel_color != due_write.pixel_color)
                        report_mismatch("pixel_color", o_resp.pixel_color,
                                        due_write.pixel_color);
                    if (o_resp.last_row != due_write.last_row)
                        report_mismatch("last_row", 32'(o_resp.last_row),
                                        32'(due_write.last_row));
                end
            end
            req_taken = i_valid && !o_stall;
            if (req_taken) begin
                predict_request(i_req);
                reqs_taken++;
            end
            if (req_taken || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Request driver. A request stays on the bus, unchanged, until it is
    // taken; between requests the sender may pause for a burst of cycles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !req_taken) begin
            // Still waiting for the block to take the current request.
        end else if (src_gap_left > 0) begin
            i_valid <= 1'b0;
            src_gap_left--;
        end else if (requests_pending.size() > 0) begin
            if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
                i_valid <= 1'b0;
                src_gap_left = $urandom_range(0, 16);
            end else begin
                i_req   <= requests_pending.pop_front();
                i_valid <= 1'b1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Result receiver: stalls in random bursts.
    always @(negedge i_clk) begin
        if (sink_gap_left > 0) begin
            i_stall <= 1'b1;
            sink_gap_left--;
        end else if (sink_gap_pct != 0 && $urandom_range(0, 99) < sink_gap_pct) begin
            i_stall <= 1'b1;
            sink_gap_left = $urandom_range(0, 16);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic push_load(input logic [7:0] code, input logic [3:0] row,
                             input logic [7:0] bits);
        t_req r;
        r.command    = CMD_LOAD;
        r.new_run    = 1'($urandom);
        r.cell_x     = 16'($urandom);
        r.cell_y     = 16'($urandom);
        r.glyph_code = code;
        r.font_row   = row;
        r.font_bits  = bits;
        r.ink_color  = $urandom;
        r.bold       = 1'($urandom);
        r.underline  = 1'($urandom);
        requests_pending.push_back(r);
        reqs_queued++;
        // A glyph becomes drawable once every one of its rows has been written.
        if (rows_loaded[code] != 16'hFFFF) begin
            rows_loaded[code][row] = 1'b1;
            if (rows_loaded[code] == 16'hFFFF) ready_glyphs.push_back(code);
        end
    endtask

    task automatic push_draw(input logic new_run, input int x, input int y,
                             input logic [7:0] code, input logic bold,
                             input logic uline, input logic [31:0] ink);
        t_req r;
        r.command    = CMD_DRAW;
        r.new_run    = new_run;
        r.cell_x     = 16'(x);
        r.cell_y     = 16'(y);
        r.glyph_code = code;
        r.font_row   = 4'($urandom);
        r.font_bits  = 8'($urandom);
        r.ink_color  = ink;
        r.bold       = bold;
        r.underline  = uline;
        requests_pending.push_back(r);
        reqs_queued++;
    endtask

    // Random traffic is mostly well-formed: whole glyphs are loaded in a
    // shuffled row order and then drawn, mostly around the visible frame so
    // that clipping on all four sides is met often. Now and then a single row
    // is rewritten, and some draws land anywhere in the coordinate space.
    task automatic queue_random_requests(input int count);
        int made;
        int gw;
        int gh;
        int order [CELL_ROWS];
        int j;
        int tmp;
        logic [7:0] code;
        made = 0;
        gw = (frame_w > DIM_W'(FRAME_MAX)) ? FRAME_MAX : int'(frame_w);
        gh = (frame_h > DIM_W'(FRAME_MAX)) ? FRAME_MAX : int'(frame_h);
        while (made < count) begin
            if (ready_glyphs.size() < 3 || $urandom_range(0, 24) == 0) begin
                code = 8'($urandom);
                for (int i = 0; i < CELL_ROWS; i++) order[i] = i;
                for (int i = CELL_ROWS - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < CELL_ROWS; i++) begin
                    push_load(code, 4'(order[i]), 8'($urandom));
                end
                made += CELL_ROWS;
            end else if ($urandom_range(0, 9) == 0) begin
                push_load(8'($urandom), 4'($urandom), 8'($urandom));
                made++;
            end else begin
                code = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
                if ($urandom_range(0, 9) == 0) begin
                    push_draw(1'b1, int'(16'($urandom)), int'(16'($urandom)), code,
                              1'($urandom), 1'($urandom), $urandom);
                end else begin
                    push_draw($urandom_range(0, 9) < 6,
                              int'($urandom_range(0, gw + 16)) - 12,
                              int'($urandom_range(0, gh + 24)) - 20,
                              code, 1'($urandom), 1'($urandom), $urandom);
                end
                made++;
            end
        end
    endtask

    // Register writes happen only while the block is idle, so the shadow
    // frame size is updated at once.
    task automatic write_reg(input t_cfg_idx idx, input logic [DIM_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == CFG_FRAME_WIDTH) frame_w = value;
        else frame_h = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every request has been taken and every row write seen,
    // then gives any draw that produces nothing time to leave the block.
    task automatic wait_drained();
        while (reqs_taken != reqs_queued || row_writes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Frame sizes of the random phases: above the maximum, zero in either
    // direction, a single pixel, the maximum, small odd sizes, random sizes,
    // and the defaults again for the final phase without any idling.
    int phase_w [8] = '{8191, 0, 30, 1, 4096, 17, 0, 1024};
    int phase_h [8] = '{4096, 40, 0, 1, 5000, 23, 0, 768};
    int phase_n [8] = '{55, 20, 15, 35, 50, 50, 50, 50};

    initial begin
        logic [7:0] bits;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        src_gap_pct  = $urandom_range(0, 15);
        sink_gap_pct = $urandom_range(0, 15);

        // Directed part at the reset frame size of 1024 by 768. Glyph 255 is
        // loaded with a full row, an empty row, single edge pixels and an empty
        // bottom row so that underline alone makes that row visible.
        for (int row = 0; row < CELL_ROWS; row++) begin
            case (row)
                0:       bits = 8'hFF;
                1:       bits = 8'h00;
                2:       bits = 8'h80;
                3, 14:   bits = 8'h01;
                15:      bits = 8'h00;
                default: bits = 8'($urandom);
            endcase
            push_load(8'hFF, 4'(row), bits);
        end
        push_draw(1'b1, 0, 0, 8'hFF, 1'b0, 1'b0, 32'h0000_0000);
        // Continuing the run places the next cell eight pixels on.
        push_draw(1'b0, 0, 3, 8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF);
        // Right and bottom edges clip columns and rows.
        push_draw(1'b1, 1019, 760, 8'hFF, 1'b1, 1'b1, 32'h1234_5678);
        // Left and top edges.
        push_draw(1'b1, -3, -7, 8'hFF, 1'b0, 1'b1, 32'hA5A5_5A5A);
        // Only the bold column reaches into the frame.
        push_draw(1'b1, -8, 100, 8'hFF, 1'b1, 1'b0, 32'h0F0F_F0F0);
        // The pen wraps round from -8 to 0 within sixteen bits.
        push_draw(1'b0, 0, 200, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // Nothing visible at the coordinate extremes, and a run past the top.
        push_draw(1'b1, -32768, -32768, 8'hFF, 1'b1, 1'b1, 32'h8000_0001);
        push_draw(1'b1, 32767, 32767, 8'hFF, 1'b1, 1'b1, 32'h7FFF_FFFE);
        push_draw(1'b0, 0, 0, 8'hFF, 1'b0, 1'b1, 32'h0000_0001);
        queue_random_requests(25);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            if (p == 6) begin
                phase_w[p] = $urandom_range(1, 4096);
                phase_h[p] = $urandom_range(1, 4096);
            end
            write_reg(CFG_FRAME_WIDTH, DIM_W'(phase_w[p]));
            write_reg(CFG_FRAME_HEIGHT, DIM_W'(phase_h[p]));
            if (p == 7) begin
                src_gap_pct  = 0;
                sink_gap_pct = 0;
            end else begin
                src_gap_pct  = $urandom_range(0, 15);
                sink_gap_pct = $urandom_range(0, 15);
            end
            queue_random_requests(phase_n[p]);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
